// ===== rtl/morse_keyer_segment_encoder_unit_macros.svh =====
// assertion macros shared by the morse keyer segment encoder
`ifndef MORSE_KEYER_SEGMENT_ENCODER_UNIT_MACROS_SVH
`define MORSE_KEYER_SEGMENT_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MKE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mke_pkg.sv =====
// types, constants and the code table of the morse keyer segment encoder
package mke_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned UNITS_W = 4;
  localparam int unsigned TICKS_W = 20;
  localparam int unsigned DOT_W   = 16;
  localparam int unsigned ELEM_W  = 3;
  localparam int unsigned MAX_ELEM = 5;
  localparam int unsigned SEG_W   = 4;

  localparam logic [DOT_W-1:0]   DOT_TICKS_RESET = 16'd100;
  localparam logic [UNITS_W-1:0] UNIT_DOT        = 4'd1;
  localparam logic [UNITS_W-1:0] UNIT_DASH       = 4'd3;
  localparam logic [UNITS_W-1:0] UNIT_ELEM_GAP   = 4'd1;
  localparam logic [UNITS_W-1:0] UNIT_CHAR_GAP   = 4'd3;
  localparam logic [UNITS_W-1:0] UNIT_WORD_GAP   = 4'd7;
  localparam logic [UNITS_W-1:0] UNIT_START_MARK = 4'd1;
  localparam logic [UNITS_W-1:0] UNIT_END_MARK   = 4'd15;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE      = 8'h20;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DK_MORSE  = 2'd0,
    DK_GAP    = 2'd1,
    DK_MARKER = 2'd2
  } desc_kind_t;

  // one classified item as handed from front to back
  typedef struct packed {
    desc_kind_t              kind;
    logic [UNITS_W-1:0]      mark_units;
    logic [UNITS_W-1:0]      gap_units;
    logic [ELEM_W-1:0]       elem_len;
    logic [MAX_ELEM-1:0]     pattern;
  } desc_t;

  typedef struct packed {
    logic                    valid;
    logic [ELEM_W-1:0]       len;
    logic [MAX_ELEM-1:0]     pattern;
  } morse_code_t;

  // element i of a code sits in bit i, a set bit is a dash
  function automatic morse_code_t morse_lookup(input logic [CHAR_W-1:0] ch);
    morse_code_t c;
    c.valid = 1'b1;
    c.len = 3'd0;
    c.pattern = 5'b00000;
    case (ch)
      8'h61: begin c.len = 3'd2; c.pattern = 5'b00010; end
      8'h62: begin c.len = 3'd4; c.pattern = 5'b00001; end
      8'h63: begin c.len = 3'd4; c.pattern = 5'b00101; end
      8'h64: begin c.len = 3'd3; c.pattern = 5'b00001; end
      8'h65: begin c.len = 3'd1; c.pattern = 5'b00000; end
      8'h66: begin c.len = 3'd4; c.pattern = 5'b00100; end
      8'h67: begin c.len = 3'd3; c.pattern = 5'b00011; end
      8'h68: begin c.len = 3'd4; c.pattern = 5'b00000; end
      8'h69: begin c.len = 3'd2; c.pattern = 5'b00000; end
      8'h6a: begin c.len = 3'd4; c.pattern = 5'b01110; end
      8'h6b: begin c.len = 3'd3; c.pattern = 5'b00101; end
      8'h6c: begin c.len = 3'd4; c.pattern = 5'b00010; end
      8'h6d: begin c.len = 3'd2; c.pattern = 5'b00011; end
      8'h6e: begin c.len = 3'd2; c.pattern = 5'b00001; end
      8'h6f: begin c.len = 3'd3; c.pattern = 5'b00111; end
      8'h70: begin c.len = 3'd4; c.pattern = 5'b00110; end
      8'h71: begin c.len = 3'd4; c.pattern = 5'b01011; end
      8'h72: begin c.len = 3'd3; c.pattern = 5'b00010; end
      8'h73: begin c.len = 3'd3; c.pattern = 5'b00000; end
      8'h74: begin c.len = 3'd1; c.pattern = 5'b00001; end
      8'h75: begin c.len = 3'd3; c.pattern = 5'b00100; end
      8'h76: begin c.len = 3'd4; c.pattern = 5'b01000; end
      8'h77: begin c.len = 3'd3; c.pattern = 5'b00110; end
      8'h78: begin c.len = 3'd4; c.pattern = 5'b01001; end
      8'h79: begin c.len = 3'd4; c.pattern = 5'b01101; end
      8'h7a: begin c.len = 3'd4; c.pattern = 5'b00011; end
      8'h30: begin c.len = 3'd5; c.pattern = 5'b11111; end
      8'h31: begin c.len = 3'd5; c.pattern = 5'b11110; end
      8'h32: begin c.len = 3'd5; c.pattern = 5'b11100; end
      8'h33: begin c.len = 3'd5; c.pattern = 5'b11000; end
      8'h34: begin c.len = 3'd5; c.pattern = 5'b10000; end
      8'h35: begin c.len = 3'd5; c.pattern = 5'b00000; end
      8'h36: begin c.len = 3'd5; c.pattern = 5'b00001; end
      8'h37: begin c.len = 3'd5; c.pattern = 5'b00011; end
      8'h38: begin c.len = 3'd5; c.pattern = 5'b00111; end
      8'h39: begin c.len = 3'd5; c.pattern = 5'b01111; end
      default: begin c.valid = 1'b0; end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mke_queue.sv =====
// two-entry descriptor queue between front and back
module mke_queue
  import mke_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output desc_t pop_desc
);

  logic [1:0] cnt;
  desc_t      slot0;
  desc_t      slot1;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_desc   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          slot0 <= push_desc;
        end else begin
          slot1 <= push_desc;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          slot0 <= push_desc;
        end else begin
          slot0 <= slot1;
          slot1 <= push_desc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/mke_front.sv =====
// input side: takes items and classifies them into segment descriptors
module mke_front
  import mke_pkg::*;
(
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // char_code
  input  logic [1:0]        s_tuser,   // cmd
  output logic              push,
  output desc_t             push_desc,
  input  logic              push_ready
);

  morse_code_t code;
  cmd_t        cmd;

  assign cmd      = cmd_t'(s_tuser);
  assign code     = morse_lookup(s_tdata);
  assign s_tready = push_ready;

  always_comb begin
    push_desc.kind       = DK_GAP;
    push_desc.mark_units = UNIT_START_MARK;
    push_desc.gap_units  = UNIT_CHAR_GAP;
    push_desc.elem_len   = code.len;
    push_desc.pattern    = code.pattern;
    push = s_tvalid && push_ready;
    case (cmd)
      CMD_CHAR: begin
        if (s_tdata == CHAR_SPACE) begin
          push_desc.gap_units = UNIT_WORD_GAP;
        end else if (code.valid) begin
          push_desc.kind = DK_MORSE;
        end
      end
      CMD_START: begin
        push_desc.kind       = DK_MARKER;
        push_desc.mark_units = UNIT_START_MARK;
        push_desc.gap_units  = UNIT_ELEM_GAP;
      end
      CMD_END: begin
        push_desc.kind       = DK_MARKER;
        push_desc.mark_units = UNIT_END_MARK;
        push_desc.gap_units  = UNIT_ELEM_GAP;
      end
      default: begin
        // unused command is taken and dropped
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mke_back.sv =====
// output side: steps through one descriptor a segment per cycle while the output is not stalled
`include "morse_keyer_segment_encoder_unit_macros.svh"

module mke_back
  import mke_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic [DOT_W-1:0]              dot_ticks,
  input  logic                          q_valid,
  input  desc_t                         q_desc,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [TICKS_W+UNITS_W-1:0]    m_tdata,   // length_units, length_ticks
  output logic                          m_tuser,   // key_down
  output logic                          m_tlast
);

  logic                busy;
  desc_t               cur;
  logic [SEG_W-1:0]    seg;
  logic                out_free;
  logic                emit;
  logic [ELEM_W-1:0]   elem;
  logic                elem_last;
  logic                seg_key;
  logic [UNITS_W-1:0]  seg_units;
  logic                seg_last;
  logic [UNITS_W-1:0]  units;
  logic [TICKS_W-1:0]  ticks;

  assign out_free  = !m_tvalid || m_tready;
  assign emit      = busy && out_free;
  assign elem      = seg[SEG_W-1:1];
  assign elem_last = (elem == (cur.elem_len - 3'd1));
  assign q_pop     = q_valid && (!busy || (emit && seg_last));
  assign m_tdata   = {ticks, units};

  always_comb begin
    seg_key   = 1'b0;
    seg_units = cur.gap_units;
    seg_last  = 1'b1;
    case (cur.kind)
      DK_MORSE: begin
        if (!seg[0]) begin
          seg_key   = 1'b1;
          seg_units = cur.pattern[elem] ? UNIT_DASH : UNIT_DOT;
          seg_last  = 1'b0;
        end else begin
          seg_units = elem_last ? UNIT_CHAR_GAP : UNIT_ELEM_GAP;
          seg_last  = elem_last;
        end
      end
      DK_MARKER: begin
        if (!seg[0]) begin
          seg_key   = 1'b1;
          seg_units = cur.mark_units;
          seg_last  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && seg_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
      seg <= '0;
    end else if (emit) begin
      seg <= seg + 4'd1;
    end
    if (emit) begin
      m_tuser <= seg_key;
      m_tlast <= seg_last;
      units   <= seg_units;
      ticks   <= TICKS_W'(seg_units) * TICKS_W'(dot_ticks);
    end
  end

  `MKE_ASSERT_NEXT(a_done_goes_idle, emit && seg_last && !q_pop, !busy, "back still busy after last segment")
  `MKE_ASSERT_NOW(a_elem_in_range, busy && cur.kind == DK_MORSE, elem < cur.elem_len, "segment index past code length")
  `MKE_ASSERT_NEXT(a_emit_shows, emit, m_tvalid, "emitted segment not presented")

endmodule

// ===== rtl/morse_keyer_segment_encoder_unit.sv =====
// top level of the morse keyer segment encoder
// an item goes through the queue into the sequencer, which registers each output segment
// throughput: one segment per cycle unless the output stalls; up to 10 segments per item
// the input side takes an item per cycle while the two-entry queue has room
// reset: synchronous, clears queue, sequencer and output valid; dot_ticks returns to 100
module morse_keyer_segment_encoder_unit
  import mke_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [DOT_W-1:0]            cfg_wr_data,   // dot_ticks
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [CHAR_W-1:0]           s_tdata,       // char_code
  input  logic [1:0]                  s_tuser,       // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [TICKS_W+UNITS_W-1:0]  m_tdata,       // length_units, length_ticks
  output logic                        m_tuser,       // key_down
  output logic                        m_tlast
);

  logic [DOT_W-1:0] dot_ticks;
  logic             push;
  logic             push_ready;
  desc_t            push_desc;
  logic             q_valid;
  logic             q_pop;
  desc_t            q_desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= DOT_TICKS_RESET;
    end else if (cfg_wr_en) begin
      dot_ticks <= cfg_wr_data;
    end
  end

  mke_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  mke_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_desc   (q_desc)
  );

  mke_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dot_ticks (dot_ticks),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== tb/morse_keyer_segment_encoder_unit_checker.sv =====
// checker for the morse keyer segment encoder: predicts key segments and compares them
module morse_keyer_segment_encoder_unit_checker
  import mke_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [DOT_W-1:0]            cfg_wr_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [CHAR_W-1:0]           s_tdata,    // char_code
  input  logic [1:0]                  s_tuser,    // cmd
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [TICKS_W+UNITS_W-1:0]  m_tdata,    // length_units, length_ticks
  input  logic                        m_tuser,    // key_down
  input  logic                        m_tlast,
  output int                          pending,
  output int                          fail_count
);

  typedef struct packed {
    logic               key_down;
    logic [UNITS_W-1:0] units;
    logic [TICKS_W-1:0] ticks;
    logic               last;
  } segment_t;

  segment_t         seg_due[$];
  logic [DOT_W-1:0] dot_ticks_q;
  int               errs;

  function automatic string morse_of(int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      26: return "-----";
      27: return ".----";
      28: return "..---";
      29: return "...--";
      30: return "....-";
      31: return ".....";
      32: return "-....";
      33: return "--...";
      34: return "---..";
      35: return "----.";
      default: return "";
    endcase
  endfunction

  task automatic add_segment(logic key, logic [UNITS_W-1:0] units, logic last);
    segment_t s;
    logic [DOT_W+UNITS_W-1:0] prod;
    prod = units * dot_ticks_q;
    s.key_down = key;
    s.units = units;
    s.ticks = prod[TICKS_W-1:0];
    s.last = last;
    seg_due.push_back(s);
  endtask

  task automatic queue_segments_for(cmd_t cmd, logic [CHAR_W-1:0] ch);
    int idx;
    string code;
    idx = -1;
    case (cmd)
      CMD_START: begin
        add_segment(1'b1, UNIT_START_MARK, 1'b0);
        add_segment(1'b0, UNIT_ELEM_GAP, 1'b1);
      end
      CMD_END: begin
        add_segment(1'b1, UNIT_END_MARK, 1'b0);
        add_segment(1'b0, UNIT_ELEM_GAP, 1'b1);
      end
      CMD_CHAR: begin
        if (ch >= 8'h61 && ch <= 8'h7a) idx = ch - 8'h61;
        else if (ch >= 8'h30 && ch <= 8'h39) idx = 26 + ch - 8'h30;
        if (ch == CHAR_SPACE) begin
          add_segment(1'b0, UNIT_WORD_GAP, 1'b1);
        end else if (idx < 0) begin
          add_segment(1'b0, UNIT_CHAR_GAP, 1'b1);
        end else begin
          code = morse_of(idx);
          for (int i = 0; i < code.len(); i++) begin
            add_segment(1'b1, (code[i] == "-") ? UNIT_DASH : UNIT_DOT, 1'b0);
            if (i < code.len() - 1) add_segment(1'b0, UNIT_ELEM_GAP, 1'b0);
            else add_segment(1'b0, UNIT_CHAR_GAP, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_segment();
    segment_t e;
    if (seg_due.size() == 0) begin
      $error("segment with no item to account for it");
      errs++;
    end else begin
      e = seg_due.pop_front();
      if (m_tuser !== e.key_down) begin
        $error("key_down: expected %0d, got %0d", e.key_down, m_tuser);
        errs++;
      end
      if (m_tdata[UNITS_W-1:0] !== e.units) begin
        $error("length_units: expected %0d, got %0d", e.units, m_tdata[UNITS_W-1:0]);
        errs++;
      end
      if (m_tdata[TICKS_W+UNITS_W-1:UNITS_W] !== e.ticks) begin
        $error("length_ticks: expected %0d, got %0d", e.ticks,
               m_tdata[TICKS_W+UNITS_W-1:UNITS_W]);
        errs++;
      end
      if (m_tlast !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, m_tlast);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seg_due.delete();
      dot_ticks_q = DOT_TICKS_RESET;
    end else begin
      if (m_tvalid && m_tready) check_segment();
      if (s_tvalid && s_tready) queue_segments_for(cmd_t'(s_tuser), s_tdata);
      if (cfg_wr_en) dot_ticks_q = cfg_wr_data;
    end
    pending <= seg_due.size();
    fail_count <= errs;
  end

endmodule

// ===== tb/morse_keyer_segment_encoder_unit_tb.sv =====
// testbench top for the morse keyer segment encoder: stimulus, flow control and verdict
module morse_keyer_segment_encoder_unit_tb
  import mke_pkg::*;
();

  localparam int LIMIT = 500000;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [DOT_W-1:0]            cfg_wr_data;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [CHAR_W-1:0]           s_tdata;   // char_code
  logic [1:0]                  s_tuser;   // cmd
  logic                        m_tvalid;
  logic                        m_tready;
  logic [TICKS_W+UNITS_W-1:0]  m_tdata;   // length_units, length_ticks
  logic                        m_tuser;   // key_down
  logic                        m_tlast;

  int   pending;
  int   fail_count;
  int   cycles;
  int   stall_left;
  logic calm;

  morse_keyer_segment_encoder_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  morse_keyer_segment_encoder_unit_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .pending(pending), .fail_count(fail_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    int idx;
    r = $urandom_range(0, 9);
    idx = $urandom_range(0, 35);
    if (r < 7) return (idx < 26) ? CHAR_W'(8'h61 + idx) : CHAR_W'(8'h30 + idx - 26);
    if (r == 7) return CHAR_SPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_item(cmd_t cmd, logic [CHAR_W-1:0] ch);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_dot_ticks(logic [DOT_W-1:0] v);
    drain();
    repeat (12) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(int want);
    int sent;
    int n;
    cmd_t c;
    sent = 0;
    while (sent < want) begin
      if ($urandom_range(0, 9) < 8) begin
        // frame: start, a few characters, end
        send_item(CMD_START, CHAR_W'($urandom_range(0, 255)));
        n = $urandom_range(2, 7);
        for (int i = 0; i < n; i++) send_item(CMD_CHAR, pick_char());
        send_item(CMD_END, CHAR_W'($urandom_range(0, 255)));
        sent += n + 2;
      end else begin
        c = cmd_t'($urandom_range(0, 3));
        send_item(c, CHAR_W'($urandom_range(0, 255)));
        if (c != CMD_NONE) sent++;
      end
    end
  endtask

  initial begin
    logic [DOT_W-1:0] dot_set [6];
    calm = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_CHAR;
    dot_set[0] = 16'hffff;
    dot_set[1] = 16'd1;
    dot_set[2] = 16'd0;
    dot_set[3] = DOT_W'($urandom_range(2, 65534));
    dot_set[4] = 16'd3;
    dot_set[5] = DOT_TICKS_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_START, 8'h00);
    send_item(CMD_CHAR, 8'h61);
    send_item(CMD_CHAR, 8'h7a);
    send_item(CMD_CHAR, 8'h30);
    send_item(CMD_CHAR, 8'h39);
    send_item(CMD_CHAR, 8'h65);
    send_item(CMD_CHAR, 8'h74);
    send_item(CMD_CHAR, 8'h35);
    send_item(CMD_CHAR, 8'h71);
    send_item(CMD_CHAR, CHAR_SPACE);
    send_item(CMD_CHAR, 8'h41);
    send_item(CMD_CHAR, 8'h00);
    send_item(CMD_CHAR, 8'hff);
    send_item(CMD_CHAR, 8'h60);
    send_item(CMD_CHAR, 8'h7b);
    send_item(CMD_CHAR, 8'h2f);
    send_item(CMD_CHAR, 8'h3a);
    send_item(CMD_NONE, 8'hff);
    send_item(CMD_NONE, 8'h00);
    send_item(CMD_END, 8'hff);
    send_random(35);

    for (int p = 0; p < 6; p++) begin
      set_dot_ticks(dot_set[p]);
      calm = (p == 1 || p == 4);
      send_random(35);
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
